>>> hw/rtl/distinct_key_frequency_counter_assert.svh
// Assertion macros for the distinct key frequency counter.
// Needs signals clk and rst in the scope that expands them.
`ifndef DISTINCT_KEY_FREQUENCY_COUNTER_ASSERT_SVH
`define DISTINCT_KEY_FREQUENCY_COUNTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DKFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("dkfc: assertion failed");
`define DKFC_ASSERT_NEXT(lbl, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
    else $error("dkfc: assertion failed");
`else
`define DKFC_ASSERT(lbl, prop)
`define DKFC_ASSERT_NEXT(lbl, cause, effect)
`endif

`endif

>>> hw/rtl/dkfc_pkg.sv
// Shared types and constants for the distinct key frequency counter.
// No dependencies.
`default_nettype none

package dkfc_pkg;

  localparam int KEY_W           = 16;
  localparam int FREQ_W          = 12;
  localparam int KIND_W          = 2;
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int COUNT_MAX_DEF   = 4095;

  localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MAX   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MIN   = 2'd2;

  localparam logic [1:0] OP_HOLD  = 2'd0;
  localparam logic [1:0] OP_COUNT = 2'd1;
  localparam logic [1:0] OP_SHIFT = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
  } key_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]  value;
    logic [FREQ_W-1:0] frequency;
    logic [KIND_W-1:0] kind;
    logic              overflowed;
    logic              final_res;
  } res_item_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/dkfc_cell.sv
// One table cell: holds a key and its count, matches the broadcast key,
// and takes its neighbor's contents on a shift. Depends on dkfc_pkg.
`default_nettype none

module dkfc_cell #(
  parameter int IDX       = 0,
  parameter int UW        = 6,
  parameter int CW        = 12,
  parameter int COUNT_MAX = dkfc_pkg::COUNT_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire dkfc_pkg::cell_ctl_t         ctl,
  input  wire logic                        alloc,
  input  wire logic [UW-1:0]               used,
  input  wire logic [dkfc_pkg::KEY_W-1:0]  nxt_key,
  input  wire logic [CW-1:0]               nxt_cnt,
  output logic [dkfc_pkg::KEY_W-1:0]       key,
  output logic [CW-1:0]                    cnt,
  output logic                             hit
);

  assign hit = (UW'(IDX) < used) && (key == ctl.key);

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      dkfc_pkg::OP_COUNT: begin
        if (alloc && (used == UW'(IDX))) begin
          key <= ctl.key;
          cnt <= CW'(1);
        end else if (hit && (cnt < CW'(COUNT_MAX))) begin
          cnt <= cnt + CW'(1);
        end
      end
      dkfc_pkg::OP_SHIFT: begin
        key <= nxt_key;
        cnt <= nxt_cnt;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/distinct_key_frequency_counter.sv
// Top level of the distinct key frequency counter: cell chain, control and
// report output register. Depends on dkfc_pkg, dkfc_cell and the assert header.
//
//  channel | direction | handshake             | payload
//  key     | in        | key_valid / key_ready | key_item (key, last)
//  res     | out       | res_valid / res_ready | res_item (value .. final_res)
//
// Each key is accepted, then compared and updated in parallel in all cells;
// no key is accepted until that update ends. After the last key, the chain
// shifts n entries into the output register, one per cycle while it is free,
// then max and min, each when res_ready frees it; no key is accepted meanwhile.
// Reset needs no clearing pass; the fill count alone marks valid entries.
`default_nettype none

`include "distinct_key_frequency_counter_assert.svh"

module distinct_key_frequency_counter #(
  parameter int TABLE_DEPTH = dkfc_pkg::TABLE_DEPTH_DEF,
  parameter int COUNT_MAX   = dkfc_pkg::COUNT_MAX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 key_valid,
  output logic                      key_ready,
  input  wire dkfc_pkg::key_item_t  key_item,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output dkfc_pkg::res_item_t       res_item
);

  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int CW = $clog2(COUNT_MAX + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COUNT = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_MAXO  = 3'd3;
  localparam logic [2:0] S_MINO  = 3'd4;

  logic [2:0]                   state;
  logic [UW-1:0]                used;
  logic                         dropped;
  logic                         first;
  logic [dkfc_pkg::KEY_W-1:0]   cur_key;
  logic                         cur_last;
  logic [dkfc_pkg::KEY_W-1:0]   max_key;
  logic [CW-1:0]                max_cnt;
  logic [dkfc_pkg::KEY_W-1:0]   min_key;
  logic [CW-1:0]                min_cnt;

  dkfc_pkg::cell_ctl_t          ctl;
  logic                         alloc;
  logic                         res_free;
  logic                         res_load;
  logic [TABLE_DEPTH-1:0]       hit;
  logic [dkfc_pkg::KEY_W-1:0]   key_a [TABLE_DEPTH];
  logic [CW-1:0]                cnt_a [TABLE_DEPTH];

  assign key_ready = (state == S_IDLE);
  assign res_free  = !res_valid || res_ready;
  assign res_load  = res_free &&
                     ((state == S_DRAIN) || (state == S_MAXO) || (state == S_MINO));
  assign alloc     = !(|hit) && (used < UW'(TABLE_DEPTH));

  always_comb begin
    ctl.key = cur_key;
    ctl.op  = dkfc_pkg::OP_HOLD;
    if (state == S_COUNT) begin
      ctl.op = dkfc_pkg::OP_COUNT;
    end else if ((state == S_DRAIN) && res_free) begin
      ctl.op = dkfc_pkg::OP_SHIFT;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [dkfc_pkg::KEY_W-1:0] nxt_key;
    logic [CW-1:0]              nxt_cnt;
    if (i < TABLE_DEPTH - 1) begin : g_mid
      assign nxt_key = key_a[i+1];
      assign nxt_cnt = cnt_a[i+1];
    end else begin : g_end
      assign nxt_key = '0;
      assign nxt_cnt = '0;
    end
    dkfc_cell #(
      .IDX       (i),
      .UW        (UW),
      .CW        (CW),
      .COUNT_MAX (COUNT_MAX)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .alloc   (alloc),
      .used    (used),
      .nxt_key (nxt_key),
      .nxt_cnt (nxt_cnt),
      .key     (key_a[i]),
      .cnt     (cnt_a[i]),
      .hit     (hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      dropped   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (key_valid) begin
            cur_key  <= key_item.key;
            cur_last <= key_item.last;
            state    <= S_COUNT;
          end
        end
        S_COUNT: begin
          if (alloc) begin
            used <= used + UW'(1);
          end else if (!(|hit)) begin
            dropped <= 1'b1;
          end
          first <= 1'b1;
          state <= cur_last ? S_DRAIN : S_IDLE;
        end
        S_DRAIN: begin
          if (res_free) begin
            res_item.value      <= key_a[0];
            res_item.frequency  <= dkfc_pkg::FREQ_W'(cnt_a[0]);
            res_item.kind       <= dkfc_pkg::KIND_ENTRY;
            res_item.overflowed <= dropped;
            res_item.final_res  <= 1'b0;
            used                <= used - UW'(1);
            first               <= 1'b0;
            if (first || (cnt_a[0] > max_cnt)) begin
              max_key <= key_a[0];
              max_cnt <= cnt_a[0];
            end
            if (first || (cnt_a[0] <= min_cnt)) begin
              min_key <= key_a[0];
              min_cnt <= cnt_a[0];
            end
            if (used == UW'(1)) begin
              state <= S_MAXO;
            end
          end
        end
        S_MAXO: begin
          if (res_free) begin
            res_item.value      <= max_key;
            res_item.frequency  <= dkfc_pkg::FREQ_W'(max_cnt);
            res_item.kind       <= dkfc_pkg::KIND_MAX;
            res_item.overflowed <= dropped;
            res_item.final_res  <= 1'b0;
            state               <= S_MINO;
          end
        end
        S_MINO: begin
          if (res_free) begin
            res_item.value      <= min_key;
            res_item.frequency  <= dkfc_pkg::FREQ_W'(min_cnt);
            res_item.kind       <= dkfc_pkg::KIND_MIN;
            res_item.overflowed <= dropped;
            res_item.final_res  <= 1'b1;
            dropped             <= 1'b0;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `DKFC_ASSERT(a_used_in_range, used <= UW'(TABLE_DEPTH))
  `DKFC_ASSERT(a_single_match, (state != S_COUNT) || $onehot0(hit))
  `DKFC_ASSERT_NEXT(a_alloc_grows, (state == S_COUNT) && alloc, used == $past(used) + UW'(1))
  `DKFC_ASSERT_NEXT(a_report_empties, (state == S_MINO) && res_free, used == '0 && !dropped)

endmodule

`default_nettype wire
